// ----- src/pms_pkg.sv -----
// Shared types and constants for the per-pixel mean stacker.
// No dependencies; every other file of the block uses this package.
package pms_pkg;

	// field widths
	localparam int COLOR_W  = 2;
	localparam int PIXEL_W  = 12;
	localparam int SAMPLE_W = 16;
	localparam int MEAN_W   = 24;
	localparam int SUM_W    = 32;
	localparam int COUNT_W  = 16;
	localparam int FRAC_W   = 8;
	localparam int QUO_W    = SUM_W + FRAC_W;

	// parameter defaults
	localparam int COLORS_DEF      = 3;
	localparam int PIXELS_DEF      = 4096;
	localparam int SAMPLE_BITS_DEF = 16;

	// command queue between front and back
	localparam int FIFO_DEPTH = 2;

	// register port
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_EMPTY_VALUE = REG_IDX_W'(0);

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// command field codes
	localparam logic CMD_ACC  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef enum logic [1:0] {
		KIND_ACC,
		KIND_READ,
		KIND_READ_NONE
	} pms_kind_t;

	typedef struct packed {
		pms_kind_t             kind;
		logic [COLOR_W-1:0]    color;
		logic [PIXEL_W-1:0]    pixel;
		logic [SAMPLE_W-1:0]   sample;
	} pms_cmd_t;

	typedef struct packed {
		logic [SUM_W-1:0]   sum;
		logic [COUNT_W-1:0] count;
	} pms_word_t;

endpackage

// ----- src/pms_if.sv -----
// Valid/ready channel interfaces for sample words in and mean words out.
// Depends on pms_pkg for field widths.
interface pms_in_if;
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic [pms_pkg::COLOR_W-1:0]   color_index;
	logic [pms_pkg::PIXEL_W-1:0]   pixel_index;
	logic [pms_pkg::SAMPLE_W-1:0]  sample_value;

	modport source (output valid, command, color_index, pixel_index, sample_value,
		input ready);
	modport sink (input valid, command, color_index, pixel_index, sample_value,
		output ready);
endinterface

interface pms_out_if;
	logic                         valid;
	logic                         ready;
	logic [pms_pkg::COLOR_W-1:0]  out_color;
	logic [pms_pkg::PIXEL_W-1:0]  out_pixel;
	logic [pms_pkg::MEAN_W-1:0]   mean_value;
	logic                         was_empty;

	modport source (output valid, out_color, out_pixel, mean_value, was_empty,
		input ready);
	modport sink (input valid, out_color, out_pixel, mean_value, was_empty,
		output ready);
endinterface

// ----- src/pms_front.sv -----
// Front end: takes input words, checks the address and classifies the command.
// Depends on pms_pkg and pms_if.
module pms_front #(
	parameter int COLORS      = pms_pkg::COLORS_DEF,
	parameter int PIXELS      = pms_pkg::PIXELS_DEF,
	parameter int SAMPLE_BITS = pms_pkg::SAMPLE_BITS_DEF
) (
	pms_in_if.sink              in_ch,
	input  logic                accept_en,
	output logic                push,
	output pms_pkg::pms_cmd_t   cmd
);
	import pms_pkg::*;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((32'd1 << SAMPLE_BITS) - 1);

	logic addr_ok;

	assign addr_ok = (32'(in_ch.color_index) < COLORS) && (32'(in_ch.pixel_index) < PIXELS);

	assign in_ch.ready = accept_en;

	// accumulates to a bad address have no effect: drop them here
	assign push = in_ch.valid && accept_en && ((in_ch.command == CMD_READ) || addr_ok);

	always_comb begin
		cmd.color  = in_ch.color_index;
		cmd.pixel  = in_ch.pixel_index;
		cmd.sample = in_ch.sample_value & SAMPLE_MASK;
		if (in_ch.command == CMD_READ) begin
			cmd.kind = addr_ok ? KIND_READ : KIND_READ_NONE;
		end else begin
			cmd.kind = KIND_ACC;
		end
	end
endmodule

// ----- src/pms_fifo.sv -----
// Short command queue between front and back end.
// Depends on pms_pkg.
module pms_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pms_pkg::pms_cmd_t   din,
	output logic                full,
	input  logic                pop,
	output pms_pkg::pms_cmd_t   dout,
	output logic                empty
);
	import pms_pkg::*;

	localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	pms_cmd_t        slot_q [FIFO_DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;

	assign full  = (cnt_q == CW'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end
endmodule

// ----- src/pms_div.sv -----
// Restoring divider, one quotient bit per cycle, for the mean readout.
// Depends on pms_pkg.
module pms_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pms_pkg::QUO_W-1:0]     dividend,
	input  logic [pms_pkg::COUNT_W-1:0]   divisor,
	output logic                          busy,
	output logic [pms_pkg::QUO_W-1:0]     quotient
);
	import pms_pkg::*;

	localparam int STEP_W = $clog2(QUO_W);

	logic                busy_q;
	logic [STEP_W-1:0]   cnt_q;
	logic [COUNT_W-1:0]  rem_q;
	logic [COUNT_W-1:0]  dvs_q;
	logic [QUO_W-1:0]    quo_q;
	logic [COUNT_W:0]    shifted;
	logic [COUNT_W:0]    diff;
	logic                fits;

	// quo_q shifts dividend bits out the top and quotient bits in the bottom
	assign shifted  = {rem_q, quo_q[QUO_W-1]};
	assign diff     = shifted - {1'b0, dvs_q};
	assign fits     = (shifted >= {1'b0, dvs_q});
	assign busy     = busy_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			quo_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= divisor;
			quo_q  <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], fits};
			if (cnt_q == STEP_W'(QUO_W - 1)) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + STEP_W'(1);
			end
		end
	end
endmodule

// ----- src/pms_back.sv -----
// Back end: sum/count memory, read-modify-write sequencer, mean divide, output register.
// Depends on pms_pkg, pms_if and pms_div.
module pms_back #(
	parameter int COLORS = pms_pkg::COLORS_DEF,
	parameter int PIXELS = pms_pkg::PIXELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [pms_pkg::MEAN_W-1:0]    empty_value,
	input  logic                          q_empty,
	input  pms_pkg::pms_cmd_t             q_head,
	output logic                          q_pop,
	output logic                          clr_busy,
	pms_out_if.source                     out_ch
);
	import pms_pkg::*;

	localparam int ENTRIES = COLORS * PIXELS;
	localparam int AW      = $clog2(ENTRIES);

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_MOD,
		S_DIV,
		S_OUT
	} state_t;

	state_t               state_q;
	logic [AW-1:0]        clr_q;
	logic [AW-1:0]        addr_q;
	logic [AW-1:0]        head_addr;
	pms_cmd_t             cmd_q;
	pms_word_t            mem [ENTRIES];
	pms_word_t            rdata_q;
	logic                 we;
	logic [AW-1:0]        waddr;
	pms_word_t            wdata;
	logic                 div_start;
	logic                 div_busy;
	logic [QUO_W-1:0]     div_quo;
	logic [MEAN_W-1:0]    res_mean_q;
	logic                 res_empty_q;
	logic                 out_valid_q;
	logic [COLOR_W-1:0]   out_color_q;
	logic [PIXEL_W-1:0]   out_pixel_q;
	logic [MEAN_W-1:0]    out_mean_q;
	logic                 out_empty_q;

	// entry = color * PIXELS + pixel
	assign head_addr = AW'(AW'(q_head.color) * AW'(PIXELS)) + AW'(q_head.pixel);

	assign q_pop    = (state_q == S_IDLE) && !q_empty;
	assign clr_busy = (state_q == S_CLR);

	always_comb begin
		we    = 1'b0;
		waddr = addr_q;
		wdata = '0;
		case (state_q)
			S_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
			end
			S_MOD: begin
				if (cmd_q.kind == KIND_ACC) begin
					// saturated entry is frozen
					if (rdata_q.count != COUNT_MAX) begin
						we          = 1'b1;
						wdata.sum   = rdata_q.sum + SUM_W'(cmd_q.sample);
						wdata.count = rdata_q.count + COUNT_W'(1);
					end
				end else begin
					we = 1'b1;
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	assign div_start = (state_q == S_MOD) && (cmd_q.kind != KIND_ACC) && (rdata_q.count != '0);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[head_addr];
	end

	pms_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({rdata_q.sum, FRAC_W'(0)}),
		.divisor  (rdata_q.count),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			addr_q      <= '0;
			cmd_q       <= '0;
			res_mean_q  <= '0;
			res_empty_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_color_q <= '0;
			out_pixel_q <= '0;
			out_mean_q  <= '0;
			out_empty_q <= 1'b0;
		end else begin
			// taken word leaves the register, unless S_OUT refills it this cycle
			if (out_valid_q && out_ch.ready && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					if (clr_q == AW'(ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (!q_empty) begin
						cmd_q  <= q_head;
						addr_q <= head_addr;
						if (q_head.kind == KIND_READ_NONE) begin
							res_mean_q  <= empty_value;
							res_empty_q <= 1'b1;
							state_q     <= S_OUT;
						end else begin
							state_q <= S_MOD;
						end
					end
				end
				S_MOD: begin
					if (cmd_q.kind == KIND_ACC) begin
						state_q <= S_IDLE;
					end else if (rdata_q.count == '0) begin
						res_mean_q  <= empty_value;
						res_empty_q <= 1'b1;
						state_q     <= S_OUT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (!div_busy) begin
						res_mean_q  <= (|div_quo[QUO_W-1:MEAN_W]) ? '1 : div_quo[MEAN_W-1:0];
						res_empty_q <= 1'b0;
						state_q     <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						out_color_q <= cmd_q.color;
						out_pixel_q <= cmd_q.pixel;
						out_mean_q  <= res_mean_q;
						out_empty_q <= res_empty_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLR;
				end
			endcase
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.out_color  = out_color_q;
	assign out_ch.out_pixel  = out_pixel_q;
	assign out_ch.mean_value = out_mean_q;
	assign out_ch.was_empty  = out_empty_q;
endmodule

// ----- src/per_pixel_mean_stacker_core.sv -----
// Top level of the per-pixel mean stacker: front end, command queue, back end, register.
// Depends on pms_pkg, pms_if, pms_front, pms_fifo and pms_back.
//
// Usage:
//  pix_in  - valid/ready channel of sample words: command (0 accumulate, 1 read out
//            and clear), color_index, pixel_index, sample_value.
//  mean_out - valid/ready channel of mean words, one per read-out word: out_color,
//            out_pixel, mean_value (unsigned, 8 fraction bits), was_empty.
//  APB     - one register, empty_value at byte address 0; write it only while idle.
// The back end takes one word at a time. An accumulate word is read from the sum/count
//  memory (one read, one write port) in S_IDLE and written back in S_MOD; a filled entry's
//  read-out then passes S_DIV (40 steps of the one-bit-per-cycle divider) and S_OUT, an
//  empty one skips S_DIV, an out-of-range one goes from S_IDLE to S_OUT. Accumulates to an
//  out-of-range address are dropped at the front and cost nothing in the back.
// An accumulate word has no result; a read-out word goes through the queue, then the
//  back-end states above, and shows on mean_out from the output register.
// Reset: arst_n clears control state and empty_value, then the back end sweeps the
//  memory to zero, one entry per cycle, all COLORS*PIXELS entries (12288 by default);
//  pix_in.ready stays low for the sweep, register writes are taken throughout.
// Stall: a result waits in the output register; the back end keeps working on
//  accumulates and the two-word queue keeps pix_in moving until it fills.
module per_pixel_mean_stacker_core #(
	parameter int COLORS      = pms_pkg::COLORS_DEF,
	parameter int PIXELS      = pms_pkg::PIXELS_DEF,
	parameter int SAMPLE_BITS = pms_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	pms_in_if.sink                        pix_in,
	pms_out_if.source                     mean_out,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pms_pkg::PADDR_W-1:0]   paddr,
	input  logic [pms_pkg::PDATA_W-1:0]   pwdata,
	output logic [pms_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import pms_pkg::*;

	logic                 accept_en;
	logic                 push;
	pms_cmd_t             cmd;
	logic                 q_full;
	logic                 q_empty;
	logic                 q_pop;
	pms_cmd_t             q_head;
	logic                 clr_busy;
	logic [MEAN_W-1:0]    empty_value_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_wr;

	// ---- register port: zero-wait APB, write lands in the access phase ----
	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign prdata  = (reg_idx == REG_EMPTY_VALUE) ? PDATA_W'(empty_value_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_value_q <= '0;
		end else if (cfg_wr && (reg_idx == REG_EMPTY_VALUE)) begin
			empty_value_q <= pwdata[MEAN_W-1:0];
		end
	end

	// front stops taking words while the queue is full or memory is being swept
	assign accept_en = !q_full && !clr_busy;

	pms_front #(
		.COLORS      (COLORS),
		.PIXELS      (PIXELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.in_ch     (pix_in),
		.accept_en (accept_en),
		.push      (push),
		.cmd       (cmd)
	);

	pms_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (cmd),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_head),
		.empty  (q_empty)
	);

	pms_back #(
		.COLORS (COLORS),
		.PIXELS (PIXELS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty_value (empty_value_q),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.clr_busy    (clr_busy),
		.out_ch      (mean_out)
	);
endmodule

// ----- src/pms_chk.sv -----
// Port-level checker for the mean stacker, bound to the top level.
// Depends on pms_pkg and per_pixel_mean_stacker_core.
module pms_chk (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          in_command,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [pms_pkg::MEAN_W-1:0]    out_mean,
	input  logic [pms_pkg::PIXEL_W-1:0]   out_pixel
);
	import pms_pkg::*;

	// read-out words accepted but not yet delivered
	logic [2:0] pend_q;
	logic       rd_in;
	logic       rd_out;

	assign rd_in  = in_valid && in_ready && (in_command == CMD_READ);
	assign rd_out = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (rd_in && !rd_out) begin
			pend_q <= pend_q + 3'd1;
		end else if (rd_out && !rd_in) begin
			pend_q <= pend_q - 3'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_mean) && $stable(out_pixel))
		else $error("stalled mean word changed");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 3'd0)
		else $error("mean word without a pending read-out");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd4)
		else $error("too many read-outs in flight");

	a_sweep_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !in_ready)
		else $error("input taken during memory sweep");
endmodule

bind per_pixel_mean_stacker_core pms_chk u_pms_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (pix_in.valid),
	.in_ready   (pix_in.ready),
	.in_command (pix_in.command),
	.out_valid  (mean_out.valid),
	.out_ready  (mean_out.ready),
	.out_mean   (mean_out.mean_value),
	.out_pixel  (mean_out.out_pixel)
);

// ----- dv/tb_per_pixel_mean_stacker_core.sv -----
`timescale 1ns / 1ps
// Testbench for per_pixel_mean_stacker_core: self-checking, with its own mean predictor.
// Depends on pms_pkg, pms_if and the RTL of the block; nothing else.
module tb_per_pixel_mean_stacker_core;
	import pms_pkg::*;

	localparam int COLORS        = COLORS_DEF;
	localparam int PIXELS        = PIXELS_DEF;
	localparam int SAMPLE_BITS   = SAMPLE_BITS_DEF;
	localparam int ENTRIES       = COLORS * PIXELS;
	// hold off before a register write for longer than the longest read-out takes
	localparam int SETTLE_CYCLES = 64;
	// covers the sweep plus ~1.6k words at their slowest, several times over
	localparam int CYCLE_LIMIT   = 500_000;
	localparam int HOT_ENTRIES   = 8;
	localparam int PHASE_WORDS   = 385;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [PIXEL_W-1:0] pixel;
		logic [MEAN_W-1:0]  mean;
		logic               empty;
	} mean_word_t;

	// Tracks per-entry sum and hit count; queues the mean words that read-outs must produce.
	class mean_scoreboard;
		logic [SUM_W-1:0]   pix_sum [ENTRIES];
		logic [COUNT_W-1:0] pix_count [ENTRIES];
		logic [MEAN_W-1:0]  empty_mean;
		mean_word_t         pending_means [$];
		int                 errors;

		function new();
			foreach (pix_sum[i]) begin
				pix_sum[i] = '0;
				pix_count[i] = '0;
			end
			empty_mean = '0;
			errors = 0;
		endfunction

		task report(input string msg);
			$display("MISMATCH @%0t: %s", $realtime, msg);
			errors++;
		endtask

		// note one accepted sample word
		function void stack_word(input logic cmd, input logic [COLOR_W-1:0] color,
				input logic [PIXEL_W-1:0] pixel, input logic [SAMPLE_W-1:0] sample);
			int unsigned      idx;
			logic             in_range;
			logic [QUO_W-1:0] quo;
			mean_word_t       res;
			in_range = (color < COLORS) && (pixel < PIXELS);
			idx = color * PIXELS + pixel;
			if (cmd == CMD_ACC) begin
				// saturated count: word dropped, sum stays consistent
				if (in_range && pix_count[idx] != COUNT_MAX) begin
					pix_sum[idx] = pix_sum[idx] + SUM_W'(sample[SAMPLE_BITS-1:0]);
					pix_count[idx] = pix_count[idx] + 1'b1;
				end
			end else begin
				res.color = color;
				res.pixel = pixel;
				if (in_range && pix_count[idx] != 0) begin
					quo = {pix_sum[idx], FRAC_W'(0)} / QUO_W'(pix_count[idx]);
					res.mean = (quo > QUO_W'({MEAN_W{1'b1}})) ? '1 : quo[MEAN_W-1:0];
					res.empty = 1'b0;
				end else begin
					res.mean = empty_mean;
					res.empty = 1'b1;
				end
				if (in_range) begin
					pix_sum[idx] = '0;
					pix_count[idx] = '0;
				end
				pending_means.push_back(res);
			end
		endfunction

		// compare one accepted mean word with the oldest expectation
		task check_mean(input mean_word_t got);
			mean_word_t exp_w;
			if (pending_means.size() == 0) begin
				report($sformatf("unexpected mean word c=%0d p=%0d m=%0h e=%0b",
					got.color, got.pixel, got.mean, got.empty));
			end else begin
				exp_w = pending_means.pop_front();
				if (got.color !== exp_w.color)
					report($sformatf("out_color %0d, want %0d", got.color, exp_w.color));
				if (got.pixel !== exp_w.pixel)
					report($sformatf("out_pixel %0d, want %0d", got.pixel, exp_w.pixel));
				if (got.mean !== exp_w.mean)
					report($sformatf("mean_value %0h, want %0h (c=%0d p=%0d)",
						got.mean, exp_w.mean, exp_w.color, exp_w.pixel));
				if (got.empty !== exp_w.empty)
					report($sformatf("was_empty %0b, want %0b (c=%0d p=%0d)",
						got.empty, exp_w.empty, exp_w.color, exp_w.pixel));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata, prdata;
	logic pready;

	pms_in_if  pix_in ();
	pms_out_if mean_out ();

	mean_scoreboard board;
	int send_idle_pct;
	int stall_pct;
	int cycle_count;

	// entries hit over and over so that sums build up between read-outs
	logic [COLOR_W-1:0] hot_color [HOT_ENTRIES] = '{0, 1, 2, 0, 1, 2, 2, 0};
	logic [PIXEL_W-1:0] hot_pixel [HOT_ENTRIES] = '{0, 4095, 1, 2048, 777, 4094, 0, 4095};

	per_pixel_mean_stacker_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_in   (pix_in),
		.mean_out (mean_out),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver: ready changes at the falling edge, words are taken at the rising edge
	always @(negedge clk)
		mean_out.ready <= ($urandom_range(99, 0) >= stall_pct);

	always @(posedge clk)
		if (arst_n && mean_out.valid && mean_out.ready)
			board.check_mean('{mean_out.out_color, mean_out.out_pixel,
				mean_out.mean_value, mean_out.was_empty});

	// Drive one sample word; entered and left at a falling edge. valid stays high
	// across back-to-back words, so it sees one assignment per step.
	task automatic send_word(input logic cmd, input logic [COLOR_W-1:0] color,
			input logic [PIXEL_W-1:0] pixel, input logic [SAMPLE_W-1:0] sample);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			pix_in.valid <= 1'b0;
			@(negedge clk);
		end
		pix_in.valid        <= 1'b1;
		pix_in.command      <= cmd;
		pix_in.color_index  <= color;
		pix_in.pixel_index  <= pixel;
		pix_in.sample_value <= sample;
		@(posedge clk);
		while (!pix_in.ready)
			@(posedge clk);
		board.stack_word(cmd, color, pixel, sample);
		@(negedge clk);
	endtask

	// hold the sender until every expected mean word has come back
	task automatic drain_results();
		pix_in.valid <= 1'b0;
		while (board.pending_means.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// APB write of empty_value once the block is idle: setup, then access phase
	task automatic write_empty_value(input logic [PDATA_W-1:0] value);
		drain_results();
		// accumulates still in the back end leave no word to wait for
		repeat (SETTLE_CYCLES) @(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_EMPTY_VALUE, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		board.empty_mean = value[MEAN_W-1:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// random words: mostly hot entries, some anywhere, a few out of range
	task automatic run_phase(input int send_pct, input int stall, input int n_words);
		int                  k;
		int                  pick;
		logic                cmd;
		logic [COLOR_W-1:0]  color;
		logic [PIXEL_W-1:0]  pixel;
		logic [SAMPLE_W-1:0] sample;
		send_idle_pct = send_pct;
		stall_pct = stall;
		for (k = 0; k < n_words; k++) begin
			if (k == n_words / 2)
				drain_results();
			pick = $urandom_range(99, 0);
			if (pick < 70) begin
				pick = $urandom_range(HOT_ENTRIES - 1, 0);
				color = hot_color[pick];
				pixel = hot_pixel[pick];
			end else if (pick < 92) begin
				color = COLOR_W'($urandom_range(COLORS - 1, 0));
				pixel = PIXEL_W'($urandom);
			end else begin
				// color plane past COLORS
				color = COLOR_W'($urandom_range((1 << COLOR_W) - 1, COLORS));
				pixel = PIXEL_W'($urandom);
			end
			cmd = ($urandom_range(99, 0) < 15) ? CMD_READ : CMD_ACC;
			pick = $urandom_range(9, 0);
			if (pick < 2)
				sample = '1;
			else if (pick < 3)
				sample = '0;
			else
				sample = SAMPLE_W'($urandom);
			send_word(cmd, color, pixel, sample);
		end
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pix_in.valid = 1'b0;
		pix_in.command = CMD_ACC;
		pix_in.color_index = '0;
		pix_in.pixel_index = '0;
		pix_in.sample_value = '0;
		mean_out.ready = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		cycle_count = 0;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// all-ones write, upper bits beyond the 24-bit field included
		write_empty_value('1);

		// directed words; pix_in.ready stays low through the clearing sweep
		send_word(CMD_READ, 0, 0, 0);                  // never-hit entry
		send_word(CMD_READ, 3, 4095, 16'hFFFF);        // color out of range
		send_word(CMD_ACC, 3, 7, 16'hFFFF);            // dropped
		send_word(CMD_READ, 3, 7, 0);
		send_word(CMD_ACC, 0, 0, 0);                   // one zero sample: mean 0, not empty
		send_word(CMD_READ, 0, 0, 16'h1234);
		send_word(CMD_ACC, 1, 4095, 16'hFFFF);
		send_word(CMD_READ, 1, 4095, 0);
		send_word(CMD_ACC, 2, 100, 1);                 // 3/2 -> fraction bits
		send_word(CMD_ACC, 2, 100, 2);
		send_word(CMD_READ, 2, 100, 0);
		send_word(CMD_ACC, 0, 5, 16'hAAAA);
		send_word(CMD_ACC, 0, 5, 16'h5555);
		send_word(CMD_ACC, 0, 5, 7);
		send_word(CMD_READ, 0, 5, 16'hFFFF);
		send_word(CMD_READ, 0, 5, 0);                  // cleared by the read above
		send_word(CMD_ACC, 2, 4095, 16'h8001);
		send_word(CMD_ACC, 2, 4095, 16'h0001);
		send_word(CMD_ACC, 2, 4095, 16'h0003);
		send_word(CMD_READ, 2, 4095, 0);
		send_word(CMD_READ, 3, 0, 0);

		// full-scale sample then a small one on a fresh entry
		send_word(CMD_ACC, 2, 2047, 16'hFFFF);
		send_word(CMD_ACC, 2, 2047, 16'h0100);
		send_word(CMD_READ, 2, 2047, 0);

		write_empty_value('0);
		run_phase(0, 0, PHASE_WORDS);
		write_empty_value($urandom);
		run_phase(65, 0, PHASE_WORDS);
		write_empty_value($urandom);
		run_phase(0, 65, PHASE_WORDS);
		write_empty_value($urandom);
		run_phase(21, 21, PHASE_WORDS);

		// wind down: everything back, then a quiet stretch for stray words
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/pms_pkg.sv
src/pms_if.sv
src/pms_front.sv
src/pms_fifo.sv
src/pms_div.sv
src/pms_back.sv
src/per_pixel_mean_stacker_core.sv
src/pms_chk.sv
dv/tb_per_pixel_mean_stacker_core.sv
